// ----- sv/assert_macros.svh -----
// Assertion macros for the unit's RTL; only c8fx_ctrl includes them.
// Each macro checks on the rising edge of clk and is disabled while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define C8FX_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("c8fx assertion failed");

// Next-cycle implication.
`define C8FX_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("c8fx assertion failed");

`endif

// ----- sv/c8fx_pkg.sv -----
// Types, codes and helper functions of the F-group instruction unit.
// Used by c8fx_ctrl, c8fx_dpath and chip8_fx_instruction_unit.
`timescale 1ns / 1ps

package c8fx_pkg;

  localparam int MEM_BYTES = 4096;
  localparam int MEM_AW    = $clog2(MEM_BYTES);

  localparam logic [2:0] OP_EXEC   = 3'd0;
  localparam logic [2:0] OP_WR_V   = 3'd1;
  localparam logic [2:0] OP_WR_MEM = 3'd2;
  localparam logic [2:0] OP_RD_MEM = 3'd3;
  localparam logic [2:0] OP_WR_I   = 3'd4;
  localparam logic [2:0] OP_WR_PC  = 3'd5;

  localparam logic [7:0] SEL_DELAY_RD = 8'h07;
  localparam logic [7:0] SEL_KEY_WAIT = 8'h0A;
  localparam logic [7:0] SEL_DELAY_WR = 8'h15;
  localparam logic [7:0] SEL_SOUND_WR = 8'h18;
  localparam logic [7:0] SEL_ADD_I    = 8'h1E;
  localparam logic [7:0] SEL_FONT     = 8'h29;
  localparam logic [7:0] SEL_BCD      = 8'h33;
  localparam logic [7:0] SEL_STORE    = 8'h55;
  localparam logic [7:0] SEL_LOAD     = 8'h65;

  localparam logic [7:0]  FONT_STRIDE = 8'h05;
  localparam logic [15:0] PC_STEP     = 16'd2;

  // Work class of a latched item, as seen by the controller.
  localparam logic [1:0] KIND_ONE   = 2'd0;
  localparam logic [1:0] KIND_READ  = 2'd1;
  localparam logic [1:0] KIND_STORE = 2'd2;
  localparam logic [1:0] KIND_LOAD  = 2'd3;

  typedef struct packed {
    logic [2:0]  operation;
    logic [15:0] instruction;
    logic [11:0] address;
    logic [3:0]  reg_index;
    logic [7:0]  byte_value;
    logic [15:0] word_value;
  } cmd_item_t;

  typedef struct packed {
    logic        status;
    logic [15:0] program_counter;
    logic [15:0] index_value;
    logic [7:0]  delay_count;
    logic [7:0]  sound_count;
    logic        key_waiting;
    logic [3:0]  key_target;
    logic [7:0]  x_register_value;
    logic [7:0]  read_byte;
  } rsp_item_t;

  // Controller to datapath.
  typedef struct packed {
    logic       latch;
    logic       apply_one;
    logic       use_k;
    logic [3:0] k;
    logic       store_step;
    logic       mem_re;
    logic       load_wb;
    logic [3:0] wb_idx;
    logic       pc_step;
    logic       load_out;
  } dp_ctl_t;

  // Datapath to controller.
  typedef struct packed {
    logic [1:0] kind;
    logic [3:0] last;
  } dp_stat_t;

  // One decimal digit of v: pos 0 hundreds, 1 tens, else ones.
  function automatic logic [7:0] bcd_digit(input logic [7:0] v, input logic [1:0] pos);
    logic [1:0]  h;
    logic [7:0]  r;
    logic [14:0] prod;
    logic [3:0]  t;
    logic [7:0]  o;
    h = (v >= 8'd200) ? 2'd2 : ((v >= 8'd100) ? 2'd1 : 2'd0);
    r = v - ((h == 2'd2) ? 8'd200 : ((h == 2'd1) ? 8'd100 : 8'd0));
    // r < 100: tens = (r * 205) >> 11
    prod = 15'(r[6:0]) * 15'd205;
    t = prod[14:11];
    o = r - 8'({4'd0, t} * 8'd10);
    case (pos)
      2'd0:    bcd_digit = {6'd0, h};
      2'd1:    bcd_digit = {4'd0, t};
      default: bcd_digit = o;
    endcase
  endfunction

endpackage

// ----- sv/c8fx_dpath.sv -----
// Datapath of the F-group unit: V registers, I, PC, timers, key wait, byte memory
// and the result register. Driven by c8fx_ctrl; uses c8fx_pkg.
`timescale 1ns / 1ps

module c8fx_dpath (
  input  logic                clk,
  input  logic                rst,
  input  c8fx_pkg::cmd_item_t cmd,
  input  c8fx_pkg::dp_ctl_t   ctl,
  output c8fx_pkg::dp_stat_t  stat,
  output c8fx_pkg::rsp_item_t rsp
);

  c8fx_pkg::cmd_item_t item;

  logic [7:0]  vregs [16];
  logic [15:0] index_reg;
  logic [15:0] pc;
  logic [7:0]  delay_tmr;
  logic [7:0]  sound_tmr;
  logic        wait_flag;
  logic [3:0]  wait_reg;

  logic [7:0]  mem [c8fx_pkg::MEM_BYTES];
  logic [7:0]  rdata;

  logic [2:0]  op;
  logic [3:0]  x;
  logic [7:0]  sel;
  logic        is_exec;
  logic        known;
  logic        bad;
  logic [3:0]  rd_idx;
  logic [7:0]  vsel;
  logic [c8fx_pkg::MEM_AW-1:0] mem_addr;
  logic [7:0]  wdata;
  logic        mem_we;

  always_ff @(posedge clk) begin
    if (ctl.latch) begin
      item <= cmd;
    end
  end

  assign op      = item.operation;
  assign x       = item.instruction[11:8];
  assign sel     = item.instruction[7:0];
  assign is_exec = (op == c8fx_pkg::OP_EXEC);

  always_comb begin
    known = sel inside {c8fx_pkg::SEL_DELAY_RD, c8fx_pkg::SEL_KEY_WAIT,
                        c8fx_pkg::SEL_DELAY_WR, c8fx_pkg::SEL_SOUND_WR,
                        c8fx_pkg::SEL_ADD_I, c8fx_pkg::SEL_FONT,
                        c8fx_pkg::SEL_BCD, c8fx_pkg::SEL_STORE, c8fx_pkg::SEL_LOAD};
    bad = (is_exec && !known) ||
          !(op inside {c8fx_pkg::OP_EXEC, c8fx_pkg::OP_WR_V, c8fx_pkg::OP_WR_MEM,
                       c8fx_pkg::OP_RD_MEM, c8fx_pkg::OP_WR_I, c8fx_pkg::OP_WR_PC});
  end

  always_comb begin
    if (is_exec && (sel == c8fx_pkg::SEL_BCD || sel == c8fx_pkg::SEL_STORE)) begin
      stat.kind = c8fx_pkg::KIND_STORE;
    end else if (is_exec && sel == c8fx_pkg::SEL_LOAD) begin
      stat.kind = c8fx_pkg::KIND_LOAD;
    end else if (op == c8fx_pkg::OP_RD_MEM) begin
      stat.kind = c8fx_pkg::KIND_READ;
    end else begin
      stat.kind = c8fx_pkg::KIND_ONE;
    end
    stat.last = (sel == c8fx_pkg::SEL_BCD) ? 4'd2 : x;
  end

  // Single V read port: V[k] while storing, else the register the result reports.
  always_comb begin
    if (ctl.use_k && sel == c8fx_pkg::SEL_STORE) begin
      rd_idx = ctl.k;
    end else if (op == c8fx_pkg::OP_WR_V) begin
      rd_idx = item.reg_index;
    end else begin
      rd_idx = x;
    end
  end

  assign vsel = vregs[rd_idx];

  always_comb begin
    if (ctl.use_k) begin
      mem_addr = index_reg[c8fx_pkg::MEM_AW-1:0] + {{(c8fx_pkg::MEM_AW-4){1'b0}}, ctl.k};
      wdata = (sel == c8fx_pkg::SEL_BCD) ? c8fx_pkg::bcd_digit(vsel, ctl.k[1:0]) : vsel;
    end else begin
      mem_addr = item.address;
      wdata    = item.byte_value;
    end
    mem_we = ctl.store_step || (ctl.apply_one && op == c8fx_pkg::OP_WR_MEM);
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= wdata;
    end
    if (ctl.mem_re) begin
      rdata <= mem[mem_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 16; i++) begin
        vregs[i] <= 8'd0;
      end
    end else if (ctl.load_wb) begin
      vregs[ctl.wb_idx] <= rdata;
    end else if (ctl.apply_one) begin
      if (is_exec && sel == c8fx_pkg::SEL_DELAY_RD) begin
        vregs[x] <= delay_tmr;
      end else if (op == c8fx_pkg::OP_WR_V) begin
        vregs[item.reg_index] <= item.byte_value;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      index_reg <= 16'd0;
      pc        <= 16'd0;
      delay_tmr <= 8'd0;
      sound_tmr <= 8'd0;
      wait_flag <= 1'b0;
      wait_reg  <= 4'd0;
    end else begin
      if (ctl.pc_step) begin
        pc <= pc + c8fx_pkg::PC_STEP;
      end
      if (ctl.apply_one) begin
        case (op)
          c8fx_pkg::OP_EXEC: begin
            if (known) begin
              pc <= pc + c8fx_pkg::PC_STEP;
            end
            case (sel)
              c8fx_pkg::SEL_KEY_WAIT: begin
                wait_flag <= 1'b1;
                wait_reg  <= x;
              end
              c8fx_pkg::SEL_DELAY_WR: delay_tmr <= vsel;
              c8fx_pkg::SEL_SOUND_WR: sound_tmr <= vsel;
              c8fx_pkg::SEL_ADD_I:    index_reg <= index_reg + {8'd0, vsel};
              c8fx_pkg::SEL_FONT:     index_reg <= {8'd0, vsel} * {8'd0, c8fx_pkg::FONT_STRIDE};
              default: ;
            endcase
          end
          c8fx_pkg::OP_WR_I:  index_reg <= item.word_value;
          c8fx_pkg::OP_WR_PC: pc        <= item.word_value;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_out) begin
      rsp.status          <= bad;
      rsp.program_counter <= pc;
      rsp.index_value     <= index_reg;
      rsp.delay_count     <= delay_tmr;
      rsp.sound_count     <= sound_tmr;
      rsp.key_waiting     <= wait_flag;
      rsp.key_target      <= wait_reg;
      rsp.x_register_value <= (is_exec || op == c8fx_pkg::OP_WR_V) ? vsel : 8'd0;
      rsp.read_byte       <= (op == c8fx_pkg::OP_RD_MEM) ? rdata : 8'd0;
    end
  end

endmodule

// ----- sv/c8fx_ctrl.sv -----
// Controller of the F-group unit: input/output handshakes and the step sequencer
// for memory copies. Commands c8fx_dpath; uses c8fx_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module c8fx_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  output logic               cmd_stall,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  input  c8fx_pkg::dp_stat_t stat,
  output c8fx_pkg::dp_ctl_t  ctl
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_EXEC  = 3'd1;
  localparam logic [2:0] ST_STORE = 3'd2;
  localparam logic [2:0] ST_LOAD  = 3'd3;
  localparam logic [2:0] ST_LTAIL = 3'd4;
  localparam logic [2:0] ST_OUT   = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;
  logic [3:0] k;
  logic [3:0] k_next;
  logic       rsp_valid_next;

  always_comb begin
    ctl        = '0;
    ctl.k      = k;
    state_next = state;
    k_next     = k;
    // hold off the sender during reset as well
    cmd_stall  = rst || (state != ST_IDLE);
    case (state)
      ST_IDLE: begin
        if (cmd_valid && !rst) begin
          ctl.latch  = 1'b1;
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        k_next = 4'd0;
        case (stat.kind)
          c8fx_pkg::KIND_ONE: begin
            ctl.apply_one = 1'b1;
            state_next    = ST_OUT;
          end
          c8fx_pkg::KIND_READ: begin
            ctl.mem_re = 1'b1;
            state_next = ST_OUT;
          end
          c8fx_pkg::KIND_STORE: state_next = ST_STORE;
          c8fx_pkg::KIND_LOAD:  state_next = ST_LOAD;
          default:              state_next = ST_OUT;
        endcase
      end
      ST_STORE: begin
        ctl.use_k      = 1'b1;
        ctl.store_step = 1'b1;
        if (k == stat.last) begin
          ctl.pc_step = 1'b1;
          state_next  = ST_OUT;
        end else begin
          k_next = k + 4'd1;
        end
      end
      ST_LOAD: begin
        // read byte k, write back byte k-1 that arrived this cycle
        ctl.use_k  = 1'b1;
        ctl.mem_re = 1'b1;
        if (k != 4'd0) begin
          ctl.load_wb = 1'b1;
          ctl.wb_idx  = k - 4'd1;
        end
        if (k == stat.last) begin
          state_next = ST_LTAIL;
        end else begin
          k_next = k + 4'd1;
        end
      end
      ST_LTAIL: begin
        ctl.load_wb = 1'b1;
        ctl.wb_idx  = k;
        ctl.pc_step = 1'b1;
        state_next  = ST_OUT;
      end
      ST_OUT: begin
        // hold until the result register is free
        if (!(rsp_valid && rsp_stall)) begin
          ctl.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    if (ctl.load_out) begin
      rsp_valid_next = 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid_next = 1'b0;
    end else begin
      rsp_valid_next = rsp_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      k         <= 4'd0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      k         <= k_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  `C8FX_ASSERT_IMP(a_no_overwrite, ctl.load_out, !(rsp_valid && rsp_stall))
  `C8FX_ASSERT_IMP(a_step_bound, (state == ST_STORE || state == ST_LOAD), k <= stat.last)
  `C8FX_ASSERT_NXT(a_tail_after_load, state == ST_LOAD && k == stat.last, state == ST_LTAIL)

endmodule

// ----- sv/chip8_fx_instruction_unit.sv -----
// CHIP-8 F-group instruction unit: top level joining c8fx_ctrl and c8fx_dpath.
// Depends on c8fx_pkg for the channel item types.
//
// Usage:
//   cmd channel (cmd_valid / cmd_stall / cmd): one item is an instruction to
//   execute or a host access (write V, write or read memory, write I or PC).
//   rsp channel (rsp_valid / rsp_stall / rsp): exactly one result item per
//   command item, in order, reporting the machine state after that item.
//   Items are worked one at a time; cmd_stall is high while an item is busy.
//   Host accesses and single-step opcodes (07 0A 15 18 1E 29, unknown) pass an
//   execute step and then the result step; FX33, FX55 and FX65 run their memory
//   copy step by step between them, FX65 with a write-back tail step after it.
//   The memory copies move one byte a cycle through the single-port byte memory.
//   The result appears on rsp in the same cycle as the next command can be taken.
//   If rsp_stall holds a result, the next item is worked up to its result and
//   then waits until the held result is taken; nothing is dropped.
//   Reset (rst, synchronous) clears V, I, PC, timers and key wait, empties the
//   result register and holds cmd_stall high; memory is not cleared.
`timescale 1ns / 1ps

module chip8_fx_instruction_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_valid,
  output logic                cmd_stall,
  input  c8fx_pkg::cmd_item_t cmd,
  output logic                rsp_valid,
  input  logic                rsp_stall,
  output c8fx_pkg::rsp_item_t rsp
);

  c8fx_pkg::dp_ctl_t  ctl;
  c8fx_pkg::dp_stat_t stat;

  c8fx_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .stat      (stat),
    .ctl       (ctl)
  );

  c8fx_dpath u_dpath (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd),
    .ctl  (ctl),
    .stat (stat),
    .rsp  (rsp)
  );

endmodule

// ----- verif/tb_chip8_fx_instruction_unit.sv -----
// Self-checking testbench for chip8_fx_instruction_unit: directed and random F-group
// instructions and host accesses, checked against a machine-state scoreboard.
// Depends on c8fx_pkg for the command and result item types and the operation codes.
`timescale 1ns / 1ps

module tb_chip8_fx_instruction_unit;
  import c8fx_pkg::*;

  localparam int          CLK_PERIOD     = 20;
  localparam int          RESET_CYCLES   = 6;
  localparam int          RANDOM_ITEMS   = 725;
  localparam int          SETTLE_CYCLES  = 40;
  localparam int unsigned TIMEOUT_CYCLES = 1000000;

  // Operation and selector codes the block must reject.
  localparam logic [2:0] OP_UNUSED_A = 3'd6;
  localparam logic [2:0] OP_UNUSED_B = 3'd7;
  localparam logic [7:0] SEL_UNUSED  = 8'hFF;

  // Tracks the machine state and the results still owed by the block.
  class fx_machine_scoreboard;
    logic [7:0]  v_regs[16];
    logic [15:0] i_reg;
    logic [15:0] pc;
    logic [7:0]  delay_t;
    logic [7:0]  sound_t;
    logic        waiting;
    logic [3:0]  wait_reg;
    logic [7:0]  mem[MEM_BYTES];
    bit          mem_valid[MEM_BYTES];
    int          written_addrs[$];
    rsp_item_t   pending_reports[$];
    int          errors;
    int          checked;
    int          execs;
    int          hosts;
    int          rejected;

    function new();
      foreach (v_regs[k]) v_regs[k] = 8'd0;
      i_reg    = 16'd0;
      pc       = 16'd0;
      delay_t  = 8'd0;
      sound_t  = 8'd0;
      waiting  = 1'b0;
      wait_reg = 4'd0;
      errors   = 0;
      checked  = 0;
      execs    = 0;
      hosts    = 0;
      rejected = 0;
    endfunction

    function logic [11:0] mem_addr(logic [15:0] base, int k);
      mem_addr = 12'(32'(base) + k);
    endfunction

    function void put_byte(logic [11:0] a, logic [7:0] value);
      mem[a] = value;
      if (!mem_valid[a]) begin
        mem_valid[a] = 1'b1;
        written_addrs.push_back(int'(a));
      end
    endfunction

    function bit range_written(logic [15:0] base, logic [3:0] x);
      range_written = 1'b1;
      for (int k = 0; k <= int'(x); k++)
        if (!mem_valid[mem_addr(base, k)]) range_written = 1'b0;
    endfunction

    // Apply one item to the tracked state and return the state report it must produce.
    function rsp_item_t advance_machine(cmd_item_t c);
      rsp_item_t  r;
      logic [3:0] x;
      logic [7:0] vx;
      r  = '0;
      x  = c.instruction[11:8];
      vx = v_regs[x];
      case (c.operation)
        OP_EXEC: begin
          execs++;
          case (c.instruction[7:0])
            SEL_DELAY_RD: v_regs[x] = delay_t;
            SEL_KEY_WAIT: begin
              waiting  = 1'b1;
              wait_reg = x;
            end
            SEL_DELAY_WR: delay_t = vx;
            SEL_SOUND_WR: sound_t = vx;
            SEL_ADD_I:    i_reg = i_reg + 16'(vx);
            SEL_FONT:     i_reg = 16'(vx) * 16'(FONT_STRIDE);
            SEL_BCD: begin
              put_byte(mem_addr(i_reg, 0), vx / 8'd100);
              put_byte(mem_addr(i_reg, 1), (vx / 8'd10) % 8'd10);
              put_byte(mem_addr(i_reg, 2), vx % 8'd10);
            end
            SEL_STORE:
              for (int k = 0; k <= int'(x); k++) put_byte(mem_addr(i_reg, k), v_regs[k]);
            SEL_LOAD:
              for (int k = 0; k <= int'(x); k++) v_regs[k] = mem[mem_addr(i_reg, k)];
            default: r.status = 1'b1;
          endcase
          if (!r.status) pc = pc + PC_STEP;
          r.x_register_value = v_regs[x];
        end
        OP_WR_V: begin
          hosts++;
          v_regs[c.reg_index] = c.byte_value;
          r.x_register_value  = c.byte_value;
        end
        OP_WR_MEM: begin
          hosts++;
          put_byte(c.address, c.byte_value);
        end
        OP_RD_MEM: begin
          hosts++;
          r.read_byte = mem[c.address];
        end
        OP_WR_I: begin
          hosts++;
          i_reg = c.word_value;
        end
        OP_WR_PC: begin
          hosts++;
          pc = c.word_value;
        end
        default: r.status = 1'b1;
      endcase
      if (r.status) rejected++;
      r.program_counter = pc;
      r.index_value     = i_reg;
      r.delay_count     = delay_t;
      r.sound_count     = sound_t;
      r.key_waiting     = waiting;
      r.key_target      = wait_reg;
      advance_machine   = r;
    endfunction

    function void note_cmd(cmd_item_t c);
      pending_reports.push_back(advance_machine(c));
    endfunction

    function int pending();
      pending = pending_reports.size();
    endfunction

    function void check_field(string name, logic [15:0] expv, logic [15:0] actv);
      if (actv !== expv) begin
        errors++;
        $display("%0t: %s expected %h got %h", $time, name, expv, actv);
      end
    endfunction

    function void check_rsp(rsp_item_t a);
      rsp_item_t e;
      if (pending_reports.size() == 0) begin
        errors++;
        $display("%0t: result with none expected, expected nothing got %h", $time, a);
        return;
      end
      e = pending_reports.pop_front();
      checked++;
      check_field("status", 16'(e.status), 16'(a.status));
      check_field("program_counter", e.program_counter, a.program_counter);
      check_field("index_value", e.index_value, a.index_value);
      check_field("delay_count", 16'(e.delay_count), 16'(a.delay_count));
      check_field("sound_count", 16'(e.sound_count), 16'(a.sound_count));
      check_field("key_waiting", 16'(e.key_waiting), 16'(a.key_waiting));
      check_field("key_target", 16'(e.key_target), 16'(a.key_target));
      check_field("x_register_value", 16'(e.x_register_value), 16'(a.x_register_value));
      check_field("read_byte", 16'(e.read_byte), 16'(a.read_byte));
    endfunction
  endclass

  logic      clk       = 1'b0;
  logic      rst       = 1'b1;
  logic      cmd_valid = 1'b0;
  logic      cmd_stall;
  cmd_item_t cmd       = '0;
  logic      rsp_valid;
  logic      rsp_stall = 1'b0;
  rsp_item_t rsp;

  fx_machine_scoreboard sb;
  int stall_left = 0;
  int cycle_no   = 0;
  int stall_roll;

  chip8_fx_instruction_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Result side: check every accepted item, stall in random bursts with quiet stretches.
  always @(posedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall) sb.check_rsp(rsp);
      cycle_no++;
      if (stall_left > 0) begin
        stall_left--;
        rsp_stall <= 1'b1;
      end else if (cycle_no % 3000 < 400) begin
        rsp_stall <= 1'b0;
      end else begin
        stall_roll = $urandom_range(0, 99);
        if (stall_roll < 72) begin
          rsp_stall <= 1'b0;
        end else if (stall_roll < 95) begin
          stall_left = $urandom_range(0, 2);
          rsp_stall <= 1'b1;
        end else begin
          stall_left = $urandom_range(9, 39);
          rsp_stall <= 1'b1;
        end
      end
    end
  end

  function automatic cmd_item_t mk_cmd(logic [2:0] op, logic [15:0] instr, logic [11:0] addr,
                                       logic [3:0] ridx, logic [7:0] bval, logic [15:0] wval);
    cmd_item_t c;
    c.operation   = op;
    c.instruction = instr;
    c.address     = addr;
    c.reg_index   = ridx;
    c.byte_value  = bval;
    c.word_value  = wval;
    mk_cmd        = c;
  endfunction

  function automatic logic [15:0] fx(logic [3:0] x, logic [7:0] sel);
    fx = {4'hF, x, sel};
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 62) pick_gap = 0;
    else if (r < 92) pick_gap = $urandom_range(1, 3);
    else pick_gap = $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] pick_selector();
    logic [7:0] sel;
    case ($urandom_range(0, 8))
      0:       sel = SEL_DELAY_RD;
      1:       sel = SEL_KEY_WAIT;
      2:       sel = SEL_DELAY_WR;
      3:       sel = SEL_SOUND_WR;
      4:       sel = SEL_ADD_I;
      5:       sel = SEL_FONT;
      6:       sel = SEL_BCD;
      7:       sel = SEL_STORE;
      default: sel = SEL_LOAD;
    endcase
    pick_selector = sel;
  endfunction

  // Every field is random; the chosen operation then gets content that reaches deep:
  // I is often written into one of three hot windows, loads and reads only touch bytes already written.
  function automatic cmd_item_t pick_random_cmd();
    cmd_item_t c;
    int        r;
    c.instruction = 16'($urandom);
    c.address     = 12'($urandom);
    c.reg_index   = 4'($urandom);
    c.byte_value  = 8'($urandom);
    c.word_value  = 16'($urandom);
    r = $urandom_range(0, 99);
    if (r < 52) c.operation = OP_EXEC;
    else if (r < 64) c.operation = OP_WR_V;
    else if (r < 73) c.operation = OP_WR_MEM;
    else if (r < 81) c.operation = OP_RD_MEM;
    else if (r < 90) c.operation = OP_WR_I;
    else if (r < 95) c.operation = OP_WR_PC;
    else c.operation = ($urandom_range(0, 1) == 0) ? OP_UNUSED_A : OP_UNUSED_B;

    case (c.operation)
      OP_EXEC: begin
        if ($urandom_range(0, 99) < 88) c.instruction[7:0] = pick_selector();
        // a load from unwritten bytes is illegal: store the same range instead
        if (c.instruction[7:0] == SEL_LOAD && !sb.range_written(sb.i_reg, c.instruction[11:8]))
          c.instruction[7:0] = SEL_STORE;
      end
      OP_WR_V: begin
        r = $urandom_range(0, 9);
        if (r == 0) c.byte_value = 8'd0;
        else if (r == 1) c.byte_value = 8'hFF;
      end
      OP_WR_MEM: begin
        if ($urandom_range(0, 1) == 0) c.address = sb.i_reg[11:0] + 12'($urandom_range(0, 20));
      end
      OP_RD_MEM: begin
        if (sb.written_addrs.size() == 0)
          c.operation = OP_WR_MEM;
        else
          c.address = 12'(sb.written_addrs[$urandom_range(0, sb.written_addrs.size() - 1)]);
      end
      OP_WR_I: begin
        r = $urandom_range(0, 99);
        if (r < 30) c.word_value = 16'h0300 + 16'($urandom_range(0, 63));
        else if (r < 50) c.word_value = 16'hFFF0 + 16'($urandom_range(0, 15));
        else if (r < 70) c.word_value = 16'h0FF0 + 16'($urandom_range(0, 15));
      end
      default: ;
    endcase
    pick_random_cmd = c;
  endfunction

  // Hold valid low for the gap, then present the item until it is taken.
  task automatic send_cmd(cmd_item_t item, int gap);
    if (gap > 0) begin
      cmd_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd       <= item;
    cmd_valid <= 1'b1;
    @(posedge clk);
    while (cmd_stall) @(posedge clk);
    sb.note_cmd(item);
  endtask

  task automatic drain_results();
    cmd_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic run_directed();
    send_cmd(mk_cmd(OP_WR_V, '0, '0, 4'd15, 8'hFF, '0), 0);
    send_cmd(mk_cmd(OP_WR_V, '0, '0, 4'd1, 8'd199, '0), 0);
    send_cmd(mk_cmd(OP_WR_I, '0, '0, '0, '0, 16'hFFFE), 0);
    // I wraps at 16 bits
    send_cmd(mk_cmd(OP_EXEC, fx(4'd15, SEL_ADD_I), '0, '0, '0, '0), 0);
    // memory addresses wrap at 12 bits from here on
    send_cmd(mk_cmd(OP_WR_I, '0, '0, '0, '0, 16'h0FFE), 0);
    send_cmd(mk_cmd(OP_EXEC, fx(4'd15, SEL_BCD), '0, '0, '0, '0), 0);
    send_cmd(mk_cmd(OP_EXEC, fx(4'd15, SEL_STORE), '0, '0, '0, '0), 0);
    send_cmd(mk_cmd(OP_EXEC, fx(4'd15, SEL_LOAD), '0, '0, '0, '0), 0);
    send_cmd(mk_cmd(OP_WR_MEM, '0, 12'hFFF, '0, 8'hA5, '0), 0);
    send_cmd(mk_cmd(OP_RD_MEM, '0, 12'hFFF, '0, '0, '0), 0);
    send_cmd(mk_cmd(OP_RD_MEM, '0, 12'h000, '0, '0, '0), 0);
    send_cmd(mk_cmd(OP_EXEC, fx(4'd1, SEL_DELAY_WR), '0, '0, '0, '0), 0);
    send_cmd(mk_cmd(OP_EXEC, fx(4'd0, SEL_DELAY_RD), '0, '0, '0, '0), 0);
    send_cmd(mk_cmd(OP_EXEC, fx(4'd15, SEL_SOUND_WR), '0, '0, '0, '0), 0);
    send_cmd(mk_cmd(OP_EXEC, fx(4'd3, SEL_KEY_WAIT), '0, '0, '0, '0), 0);
    send_cmd(mk_cmd(OP_EXEC, fx(4'd15, SEL_FONT), '0, '0, '0, '0), 0);
    // top nibble of the opcode is ignored
    send_cmd(mk_cmd(OP_EXEC, {4'h0, 4'd0, SEL_FONT}, '0, '0, '0, '0), 0);
    send_cmd(mk_cmd(OP_EXEC, fx(4'd0, SEL_UNUSED), '0, '0, '0, '0), 0);
    send_cmd(mk_cmd(OP_UNUSED_A, '0, '0, '0, '0, '0), 0);
    send_cmd(mk_cmd(OP_UNUSED_B, '1, '1, '1, '1, '1), 0);
    // PC wraps at 16 bits
    send_cmd(mk_cmd(OP_WR_PC, '0, '0, '0, '0, 16'hFFFF), 0);
    send_cmd(mk_cmd(OP_EXEC, fx(4'd14, SEL_DELAY_RD), '0, '0, '0, '0), 0);
    send_cmd(mk_cmd(OP_EXEC, fx(4'd0, SEL_BCD), '0, '0, '0, '0), 0);
    send_cmd(mk_cmd(OP_WR_I, '0, '0, '0, '0, 16'h0000), 0);
    send_cmd(mk_cmd(OP_EXEC, fx(4'd0, SEL_LOAD), '0, '0, '0, '0), 0);
  endtask

  initial begin
    int gap;
    sb = new();
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    run_directed();
    drain_results();
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      // now and then let everything in flight come back before going on
      if (n % 150 == 75) drain_results();
      gap = (n % 200 < 40) ? 0 : pick_gap();
      send_cmd(pick_random_cmd(), gap);
    end
    cmd_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("run covered %0d instructions, %0d host accesses, %0d rejected items",
             sb.execs, sb.hosts, sb.rejected);
    $display("%0d results compared, %0d memory bytes touched, %0d mismatches",
             sb.checked, sb.written_addrs.size(), sb.errors);
    if (sb.errors == 0) begin
      $display("tb_chip8_fx_instruction_unit: clean");
    end else begin
      $display("tb_chip8_fx_instruction_unit: errors");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("%0t: timeout, %0d results still expected", $time, sb.pending());
    $display("tb_chip8_fx_instruction_unit: errors");
    $finish;
  end

endmodule
